>>> sv/pese_pkg.sv
// Shared constants and controller/datapath interface types for the prefix expression evaluator.
`timescale 1ns / 1ps

package pese_pkg;

   localparam int VAL_W  = 48;
   localparam int HALF_W = VAL_W / 2;
   localparam int PROD_W = 2 * VAL_W;
   localparam int OP_W   = 3;
   localparam int ST_W   = 3;

   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};
   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};

   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
   localparam logic [OP_W-1:0] OP_END  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
   localparam logic [ST_W-1:0] ST_DIVZERO   = 3'd2;
   localparam logic [ST_W-1:0] ST_COUNT     = 3'd3;
   localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load;
      logic            push;
      logic            set_err;
      logic [ST_W-1:0] err_code;
      logic            rd;
      logic            addsub;
      logic            sub;
      logic            mul_start;
      logic            div_start;
      logic            wb;
      logic            finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_full;
      logic count_lt2;
      logic err_set;
      logic b_zero;
      logic unit_done;
   } status_type;

endpackage

>>> sv/pese_ctrl.sv
// Controller state machine that sequences each item through the evaluator datapath.
`timescale 1ns / 1ps

module pese_ctrl import pese_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_op,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output cmd_type         cmd,
   input  status_type      stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ,
      S_MUL,
      S_DIV,
      S_WB,
      S_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [OP_W-1:0] op_ff;
   logic            rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            unique case (op_ff) inside
               OP_END: begin
                  cmd.rd   = 1'b1;
                  state_in = S_EMIT;
               end
               OP_PUSH: begin
                  if (!stat.err_set) begin
                     if (stat.count_full) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_OVERFLOW;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (!stat.err_set) begin
                     if (stat.count_lt2) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ST_UNDERFLOW;
                     end else begin
                        cmd.rd   = 1'b1;
                        state_in = S_READ;
                     end
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_READ: begin
            unique case (op_ff)
               OP_MUL: begin
                  cmd.mul_start = 1'b1;
                  state_in      = S_MUL;
               end
               OP_DIV: begin
                  if (stat.b_zero) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = ST_DIVZERO;
                     state_in     = S_IDLE;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               default: begin
                  cmd.addsub = 1'b1;
                  cmd.sub    = (op_ff == OP_SUB);
                  state_in   = S_WB;
               end
            endcase
         end
         S_MUL: begin
            if (stat.unit_done) begin
               state_in = S_WB;
            end
         end
         S_DIV: begin
            if (stat.unit_done) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            cmd.wb   = 1'b1;
            state_in = S_IDLE;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load) begin
            op_ff <= req_op;
         end
      end
   end

`ifndef SYNTHESIS
   ap_wb_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |->
         ($past(state_ff) == S_READ || $past(state_ff) == S_MUL || $past(state_ff) == S_DIV))
      else $error("write-back entered from an unexpected state");

   ap_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT && op_ff == OP_END))
      else $error("result raised outside of an end item");

   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("result dropped before it was taken");
`endif

endmodule

>>> sv/pese_dp.sv
// Datapath: operand stack memory, add/subtract, iterative multiplier and divider, result register.
`timescale 1ns / 1ps

module pese_dp import pese_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              stat,
   input  logic signed [VAL_W-1:0] req_operand_value,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic [ST_W-1:0]         rsp_status
);

   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int NW  = VAL_W + FRAC_BITS;
   localparam int DCW = $clog2(NW + 1);

   function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] x);
      return x[VAL_W-1] ? (VAL_W'(0) - x) : x;
   endfunction

   // Applies the sign to a magnitude and saturates to the value range.
   function automatic logic [VAL_W-1:0] sat_of(input logic [PROD_W-1:0] m, input logic neg);
      logic [PROD_W-1:0] lim;
      lim = PROD_W'(VAL_MIN);
      if (neg) begin
         if (m > lim) return VAL_MIN;
         return VAL_W'(0) - m[VAL_W-1:0];
      end
      if (m >= lim) return VAL_MAX;
      return m[VAL_W-1:0];
   endfunction

   logic [VAL_W-1:0]  mem [STACK_DEPTH];
   logic [CW-1:0]     count_ff;
   logic [ST_W-1:0]   err_ff;
   logic [VAL_W-1:0]  val_ff, rd_a_ff, rd_b_ff, res_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [CW-1:0]     cnt_m1, cnt_m2;
   logic [AW-1:0]     wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic              wr_en;
   logic [VAL_W:0]    ext_sum;
   logic [VAL_W-1:0]  addsub_val;
   logic [ST_W-1:0]   fin_status;

   // Multiplier: four 24x24 partial products, each registered in pp_ff before it is accumulated.
   logic [VAL_W-1:0]    ma_ff, mb_ff;
   logic                neg_ff;
   logic                mul_run_ff;
   logic [2:0]          mul_k_ff;
   logic [HALF_W-1:0]   mul_x, mul_y;
   logic [2*HALF_W-1:0] mul_pp, pp_ff;
   logic [1:0]          pp_sh_ff, pp_sh_in;
   logic                pp_vld_ff;
   logic [PROD_W-1:0]   pp_ext, pp_shifted, acc_ff;
   logic                mul_done;

   // Divider: restoring, one quotient bit per cycle.
   logic              div_run_ff;
   logic [DCW-1:0]    div_cnt_ff;
   logic [NW-1:0]     num_ff;
   logic [VAL_W-1:0]  rem_ff;
   logic [VAL_W:0]    rem_sh, rem_sub;
   logic              rem_ge;
   logic              div_done;

   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);

   always_comb begin
      wr_en   = cmd.push | cmd.wb;
      wr_addr = cmd.push ? count_ff[AW-1:0] : cnt_m2[AW-1:0];
      wr_data = cmd.push ? val_ff : res_ff;
   end

   always_comb begin
      if (cmd.sub) begin
         ext_sum = {rd_a_ff[VAL_W-1], rd_a_ff} - {rd_b_ff[VAL_W-1], rd_b_ff};
      end else begin
         ext_sum = {rd_a_ff[VAL_W-1], rd_a_ff} + {rd_b_ff[VAL_W-1], rd_b_ff};
      end
      if (ext_sum[VAL_W] != ext_sum[VAL_W-1]) begin
         addsub_val = ext_sum[VAL_W] ? VAL_MIN : VAL_MAX;
      end else begin
         addsub_val = ext_sum[VAL_W-1:0];
      end
   end

   always_comb begin
      mul_x    = mul_k_ff[1] ? ma_ff[VAL_W-1:HALF_W] : ma_ff[HALF_W-1:0];
      mul_y    = mul_k_ff[0] ? mb_ff[VAL_W-1:HALF_W] : mb_ff[HALF_W-1:0];
      mul_pp   = mul_x * mul_y;
      pp_sh_in = {1'b0, mul_k_ff[1]} + {1'b0, mul_k_ff[0]};
      pp_ext   = PROD_W'(pp_ff);
      case (pp_sh_ff)
         2'd0:    pp_shifted = pp_ext;
         2'd1:    pp_shifted = pp_ext << HALF_W;
         default: pp_shifted = pp_ext << (2 * HALF_W);
      endcase
      mul_done = mul_run_ff && (mul_k_ff == 3'd5);
   end

   always_comb begin
      rem_sh   = {rem_ff, num_ff[NW-1]};
      rem_ge   = (rem_sh >= {1'b0, mb_ff});
      rem_sub  = rem_sh - {1'b0, mb_ff};
      div_done = div_run_ff && (div_cnt_ff == DCW'(NW));
   end

   always_comb begin
      if (err_ff != ST_OK) begin
         fin_status = err_ff;
      end else if (count_ff != CW'(1)) begin
         fin_status = ST_COUNT;
      end else begin
         fin_status = ST_OK;
      end
   end

   always_comb begin
      stat.count_full = (count_ff >= CW'(STACK_DEPTH));
      stat.count_lt2  = (count_ff < CW'(2));
      stat.err_set    = (err_ff != ST_OK);
      stat.b_zero     = (rd_b_ff == '0);
      stat.unit_done  = mul_done | div_done;
   end

   // Stack memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_a_ff <= mem[cnt_m1[AW-1:0]];
         rd_b_ff <= mem[cnt_m2[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         err_ff     <= ST_OK;
         mul_run_ff <= 1'b0;
         div_run_ff <= 1'b0;
         pp_vld_ff  <= 1'b0;
      end else begin
         if (cmd.finish) begin
            count_ff <= '0;
            err_ff   <= ST_OK;
         end else if (cmd.set_err) begin
            err_ff <= cmd.err_code;
         end else if (cmd.push) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.wb) begin
            count_ff <= cnt_m1;
         end

         if (cmd.mul_start) begin
            mul_run_ff <= 1'b1;
            pp_vld_ff  <= 1'b0;
         end else if (mul_run_ff) begin
            pp_vld_ff <= (mul_k_ff < 3'd4);
            if (mul_done) begin
               mul_run_ff <= 1'b0;
            end
         end

         if (cmd.div_start) begin
            div_run_ff <= 1'b1;
         end else if (div_done) begin
            div_run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff <= req_operand_value;
      end

      if (cmd.mul_start || cmd.div_start) begin
         ma_ff  <= mag_of(rd_a_ff);
         mb_ff  <= mag_of(rd_b_ff);
         neg_ff <= rd_a_ff[VAL_W-1] ^ rd_b_ff[VAL_W-1];
      end

      if (cmd.mul_start) begin
         acc_ff   <= '0;
         mul_k_ff <= 3'd0;
      end else if (mul_run_ff) begin
         if (mul_k_ff < 3'd4) begin
            pp_ff    <= mul_pp;
            pp_sh_ff <= pp_sh_in;
         end
         if (!mul_done) begin
            mul_k_ff <= mul_k_ff + 3'd1;
         end
         if (pp_vld_ff) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end

      if (cmd.div_start) begin
         num_ff     <= NW'(mag_of(rd_a_ff)) << FRAC_BITS;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (div_run_ff && !div_done) begin
         rem_ff     <= rem_ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
         num_ff     <= {num_ff[NW-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + DCW'(1);
      end

      if (cmd.addsub) begin
         res_ff <= addsub_val;
      end else if (mul_done) begin
         res_ff <= sat_of(acc_ff >> FRAC_BITS, neg_ff);
      end else if (div_done) begin
         res_ff <= sat_of(PROD_W'(num_ff), neg_ff);
      end

      if (cmd.finish) begin
         rsp_status_ff <= fin_status;
         rsp_value_ff  <= (fin_status == ST_OK) ? rd_a_ff : '0;
      end
   end

   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTHESIS
   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   ap_err_freezes: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && !cmd.finish) |=> $stable(count_ff))
      else $error("stack changed while an error is latched");

   ap_wb_two: assert property (@(posedge clock) disable iff (reset)
      cmd.wb |-> (count_ff >= CW'(2) && err_ff == ST_OK))
      else $error("write-back without two operands");
`endif

endmodule

>>> sv/prefix_expression_stack_evaluator.sv
// Top level of the prefix expression evaluator: controller plus datapath.
`timescale 1ns / 1ps

// Evaluates a prefix expression whose tokens are presented last to first, one token per
// item on the req_ channel. A push item places a signed Q31.16 value on an operand stack of
// STACK_DEPTH entries; an operator item pops the top (a) and the next entry (b) and pushes
// a op b, with sums, products and quotients saturated to 48 bits and quotients truncated
// toward zero. An end item delivers one item on the rsp_ channel: the single value left on
// the stack with status ok, or zero with the first error that was latched (underflow,
// divide by zero, stack overflow) or with the leftover-count status, and then empties the
// stack. Op codes 6 and 7 are ignored. Items are processed one at a time, and a finished
// result waits in an output register so that new items are accepted while it is pending.
// Each item steps through the controller states: a push is handled in dispatch, add and
// subtract read their operands and write back, and multiply forms four 24 by 24 partial
// products, each registered before it joins the accumulator; divide uses the restoring
// divider, one quotient bit per cycle; an end item reads the stack top and, while
// the output register still holds a result, waits until that result is taken. Stack
// entries are read through a two-port registered memory, so each operator with two
// operands passes through a read state first. The stack needs no clearing after reset.
module prefix_expression_stack_evaluator import pese_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int FRAC_BITS   = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OP_W-1:0]         req_op,
   input  logic signed [VAL_W-1:0] req_operand_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_result_value,
   output logic [ST_W-1:0]         rsp_status
);

   cmd_type    cmd;
   status_type stat;

   // The controller decodes each item and steps the datapath through read, compute and
   // write-back; it also owns the result valid flag.
   pese_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the stack, its count, the latched error, the arithmetic units and
   // the result payload register.
   pese_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operand_value (req_operand_value),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

endmodule
